### rtl/ppa3_pkg.sv
// ---------------------------------------------------------------------------
// ppa3_pkg
// Shared types, codes and width helpers for the planar polygon area block.
// ---------------------------------------------------------------------------
`default_nettype none

package ppa3_pkg;

   localparam int COORD_WIDTH_DEF = 24;
   localparam int TOL_WIDTH       = 62;
   localparam int AREA_WIDTH      = 64;
   localparam int SUM_WIDTH       = 64;
   localparam int STATUS_WIDTH    = 2;
   localparam int MCAND_WIDTH     = 128;   // serial multiplier multiplicand
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 62'd167772;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FEW       = 2'd1;
   localparam logic [1:0] ST_NONPLANAR = 2'd2;
   localparam logic [1:0] ST_DEGEN     = 2'd3;

   // datapath micro-ops
   localparam logic [3:0] OP_NOP    = 4'd0;
   localparam logic [3:0] OP_ACCEPT = 4'd1;
   localparam logic [3:0] OP_PAIR   = 4'd2;
   localparam logic [3:0] OP_CLOSE  = 4'd3;
   localparam logic [3:0] OP_NORM   = 4'd4;
   localparam logic [3:0] OP_TRIP   = 4'd5;
   localparam logic [3:0] OP_CHECK  = 4'd6;
   localparam logic [3:0] OP_MLOAD  = 4'd7;
   localparam logic [3:0] OP_MSTEP  = 4'd8;
   localparam logic [3:0] OP_MSAVE  = 4'd9;
   localparam logic [3:0] OP_SLOAD  = 4'd10;
   localparam logic [3:0] OP_SSTEP  = 4'd11;
   localparam logic [3:0] OP_DLOAD  = 4'd12;
   localparam logic [3:0] OP_DSTEP  = 4'd13;
   localparam logic [3:0] OP_EMIT   = 4'd14;

   // serial multiplier operand sources
   localparam logic [2:0] MSRC_SMAG = 3'd0;   // |S| squared
   localparam logic [2:0] MSRC_NX   = 3'd1;   // |Nx| squared
   localparam logic [2:0] MSRC_NY   = 3'd2;
   localparam logic [2:0] MSRC_NZ   = 3'd3;
   localparam logic [2:0] MSRC_XQ   = 3'd4;   // S^2 times |N|^2

   // vertex slot written on accept
   localparam logic [2:0] SLOT_FIRST  = 3'd0;
   localparam logic [2:0] SLOT_SECOND = 3'd1;
   localparam logic [2:0] SLOT_NONE   = 3'd2;

   typedef struct packed {
      logic [3:0] op;
      logic [2:0] sel;     // component, operand source or slot
      logic       half;    // which partial product of a pair
      logic       aux;     // check enable for OP_CHECK
      logic [1:0] status;  // status to publish on OP_EMIT
   } cmd_type;

   typedef struct packed {
      logic nonplanar;
      logic nc_zero;
   } flags_type;

   // normal component width
   function automatic int nrm_w(input int cw);
      return 2 * cw + 3;
   endfunction

   // multiplier operand width (iterations of the serial multiplier)
   function automatic int mplier_w(input int cw);
      return (2 * nrm_w(cw) > 64) ? 2 * nrm_w(cw) : 64;
   endfunction

   // square root width
   function automatic int root_w(input int cw);
      return (MCAND_WIDTH + mplier_w(cw)) / 2;
   endfunction

endpackage

`default_nettype wire

### rtl/ppa3_dp.sv
// ---------------------------------------------------------------------------
// ppa3_dp
// Datapath: vertex store, shared signed multiplier with accumulators, and the
// serial multiply / square root / divide used on the closing vertex.
// ---------------------------------------------------------------------------
`default_nettype none

module ppa3_dp #(
   parameter int COORD_WIDTH = ppa3_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_enable,
   input  wire logic [ppa3_pkg::TOL_WIDTH-1:0]        csr_write_data,
   input  wire logic signed [COORD_WIDTH-1:0]         vertex_x,
   input  wire logic signed [COORD_WIDTH-1:0]         vertex_y,
   input  wire logic signed [COORD_WIDTH-1:0]         vertex_z,
   input  wire ppa3_pkg::cmd_type                     cmd,
   output ppa3_pkg::flags_type                        flags,
   output logic [ppa3_pkg::AREA_WIDTH-1:0]            area,
   output logic [ppa3_pkg::STATUS_WIDTH-1:0]          status
);

   localparam int CW   = COORD_WIDTH;
   localparam int DW   = CW + 1;
   localparam int MW   = CW + 3;
   localparam int PW   = 2 * MW;
   localparam int NW   = ppa3_pkg::nrm_w(CW);
   localparam int LO   = CW + 2;
   localparam int TW   = 3 * CW + 6;
   localparam int QW   = 2 * NW;
   localparam int AW   = ppa3_pkg::MCAND_WIDTH;
   localparam int BW   = ppa3_pkg::mplier_w(CW);
   localparam int XW   = AW + BW;
   localparam int RW   = ppa3_pkg::root_w(CW);
   localparam int SW   = ppa3_pkg::SUM_WIDTH;
   localparam int OW   = ppa3_pkg::AREA_WIDTH;
   localparam int TOLW = ppa3_pkg::TOL_WIDTH;
   localparam int CMPW = (TW > TOLW) ? TW : TOLW;

   logic [2:0][CW-1:0] cur_ff, first_ff, second_ff, prev_ff;
   logic [2:0][NW-1:0] normal_ff;
   logic [2:0][SW-1:0] sums_ff;
   logic signed [TW-1:0] trip_ff;
   logic                 nonplanar_ff;
   logic [TOLW-1:0]      tol_ff;

   logic signed [PW-1:0] prod_ff;
   logic [3:0]           pop_ff;
   logic [1:0]           psel_ff;
   logic                 phalf_ff;

   logic [AW-1:0]  a_ff, s2_ff;
   logic [XW-1:0]  p_ff;
   logic [QW-1:0]  q_ff;
   logic [RW-1:0]  root_ff;
   logic [RW+1:0]  rem_ff;
   logic [OW-1:0]  area_ff;
   logic [1:0]     status_ff;

   logic [2:0][CW-1:0] pv, cv;
   logic signed [DW-1:0] d1 [3];
   logic signed [DW-1:0] d2 [3];
   logic [1:0] ai, bi, ci;
   logic signed [MW-1:0] mul_a, mul_b;

   logic [2:0][NW-1:0] nabs;
   logic [1:0]    drop;
   logic [NW-1:0] nc;
   logic [NW:0]   dvs;
   logic [SW-1:0] s_sel, smag;
   logic [TW-1:0] tabs;
   logic          exceed;
   logic [AW-1:0] ma;
   logic [BW-1:0] mb;
   logic [AW:0]   msum;
   logic [RW+1:0] rt, trial;
   logic [NW+1:0] dt;
   logic signed [TW-1:0] tterm;

   // operand selection for the shared multiplier
   always_comb begin
      case (cmd.sel[1:0])
         2'd0: begin ai = 2'd1; bi = 2'd2; end
         2'd1: begin ai = 2'd2; bi = 2'd0; end
         default: begin ai = 2'd0; bi = 2'd1; end
      endcase
      ci = (cmd.sel[1:0] == 2'd3) ? 2'd2 : cmd.sel[1:0];
      pv = (cmd.op == ppa3_pkg::OP_CLOSE) ? cur_ff : prev_ff;
      cv = (cmd.op == ppa3_pkg::OP_CLOSE) ? first_ff : cur_ff;
      for (int i = 0; i < 3; i++) begin
         d1[i] = DW'($signed(second_ff[i])) - DW'($signed(first_ff[i]));
         d2[i] = DW'($signed(cur_ff[i])) - DW'($signed(first_ff[i]));
      end
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         ppa3_pkg::OP_PAIR, ppa3_pkg::OP_CLOSE: begin
            if (cmd.half) begin
               mul_a = MW'($signed(cv[ai]));
               mul_b = MW'($signed(pv[bi]));
            end else begin
               mul_a = MW'($signed(pv[ai]));
               mul_b = MW'($signed(cv[bi]));
            end
         end
         ppa3_pkg::OP_NORM: begin
            if (cmd.half) begin
               mul_a = MW'(d1[bi]);
               mul_b = MW'(d2[ai]);
            end else begin
               mul_a = MW'(d1[ai]);
               mul_b = MW'(d2[bi]);
            end
         end
         ppa3_pkg::OP_TRIP: begin
            mul_a = MW'(d2[ci]);
            if (cmd.half) mul_b = MW'($signed(normal_ff[ci][NW-1:LO]));
            else          mul_b = $signed(MW'(normal_ff[ci][LO-1:0]));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // closing-vertex selection and the iterative step logic
   always_comb begin
      for (int i = 0; i < 3; i++)
         nabs[i] = normal_ff[i][NW-1] ? (~normal_ff[i] + NW'(1)) : normal_ff[i];
      if (nabs[0] > nabs[1]) drop = (nabs[0] > nabs[2]) ? 2'd0 : 2'd2;
      else                   drop = (nabs[1] > nabs[2]) ? 2'd1 : 2'd2;
      nc    = nabs[drop];
      dvs   = {nc, 1'b0};
      s_sel = sums_ff[drop];
      smag  = s_sel[SW-1] ? (~s_sel + SW'(1)) : s_sel;
      tabs  = trip_ff[TW-1] ? TW'(-trip_ff) : TW'(trip_ff);
      exceed = CMPW'(tabs) > CMPW'(tol_ff);
      tterm = phalf_ff ? (TW'(prod_ff) <<< LO) : TW'(prod_ff);

      case (cmd.sel)
         ppa3_pkg::MSRC_SMAG: begin ma = AW'(smag);    mb = BW'(smag);    end
         ppa3_pkg::MSRC_NX:   begin ma = AW'(nabs[0]); mb = BW'(nabs[0]); end
         ppa3_pkg::MSRC_NY:   begin ma = AW'(nabs[1]); mb = BW'(nabs[1]); end
         ppa3_pkg::MSRC_NZ:   begin ma = AW'(nabs[2]); mb = BW'(nabs[2]); end
         default:             begin ma = s2_ff;        mb = BW'(q_ff);    end
      endcase
      msum  = {1'b0, p_ff[XW-1:BW]} + (p_ff[0] ? {1'b0, a_ff} : '0);
      rt    = {rem_ff[RW-1:0], p_ff[XW-1:XW-2]};
      trial = {root_ff, 2'b01};
      dt    = {rem_ff[NW:0], root_ff[RW-1]};
   end

   always_ff @(posedge clock) begin
      // product stage
      prod_ff  <= PW'(mul_a) * PW'(mul_b);
      pop_ff   <= cmd.op;
      psel_ff  <= (cmd.sel[1:0] == 2'd3) ? 2'd2 : cmd.sel[1:0];
      phalf_ff <= cmd.half;

      if (reset) begin
         tol_ff       <= ppa3_pkg::TOL_RESET;
         normal_ff    <= '0;
         sums_ff      <= '0;
         nonplanar_ff <= 1'b0;
         pop_ff       <= ppa3_pkg::OP_NOP;
      end else begin
         if (csr_write_enable) tol_ff <= csr_write_data;

         // accumulate stage
         case (pop_ff)
            ppa3_pkg::OP_PAIR, ppa3_pkg::OP_CLOSE:
               sums_ff[psel_ff] <= phalf_ff ? sums_ff[psel_ff] - SW'(prod_ff)
                                            : sums_ff[psel_ff] + SW'(prod_ff);
            ppa3_pkg::OP_NORM:
               normal_ff[psel_ff] <= phalf_ff ? normal_ff[psel_ff] - NW'(prod_ff)
                                              : normal_ff[psel_ff] + NW'(prod_ff);
            ppa3_pkg::OP_TRIP:
               trip_ff <= trip_ff + tterm;
            default: ;
         endcase

         case (cmd.op)
            ppa3_pkg::OP_ACCEPT: begin
               cur_ff  <= {vertex_z, vertex_y, vertex_x};
               trip_ff <= '0;
               if (cmd.sel == ppa3_pkg::SLOT_FIRST)
                  first_ff <= {vertex_z, vertex_y, vertex_x};
               if (cmd.sel == ppa3_pkg::SLOT_SECOND)
                  second_ff <= {vertex_z, vertex_y, vertex_x};
            end
            ppa3_pkg::OP_CHECK: begin
               prev_ff <= cur_ff;
               if (cmd.aux && exceed) nonplanar_ff <= 1'b1;
            end
            ppa3_pkg::OP_MLOAD: begin
               a_ff <= ma;
               p_ff <= {{AW{1'b0}}, mb};
            end
            ppa3_pkg::OP_MSTEP:
               p_ff <= {msum, p_ff[BW-1:1]};
            ppa3_pkg::OP_MSAVE: begin
               case (cmd.sel)
                  ppa3_pkg::MSRC_SMAG: s2_ff <= p_ff[AW-1:0];
                  ppa3_pkg::MSRC_NX:   q_ff  <= p_ff[QW-1:0];
                  ppa3_pkg::MSRC_NY,
                  ppa3_pkg::MSRC_NZ:   q_ff  <= q_ff + p_ff[QW-1:0];
                  default: ;
               endcase
            end
            ppa3_pkg::OP_SLOAD: begin
               root_ff <= '0;
               rem_ff  <= '0;
            end
            ppa3_pkg::OP_SSTEP: begin
               p_ff    <= {p_ff[XW-3:0], 2'b00};
               rem_ff  <= (rt >= trial) ? rt - trial : rt;
               root_ff <= {root_ff[RW-2:0], rt >= trial};
            end
            ppa3_pkg::OP_DLOAD:
               rem_ff <= '0;
            ppa3_pkg::OP_DSTEP: begin
               rem_ff  <= (RW+2)'((dt >= {1'b0, dvs}) ? dt - {1'b0, dvs} : dt);
               root_ff <= {root_ff[RW-2:0], dt >= {1'b0, dvs}};
            end
            ppa3_pkg::OP_EMIT: begin
               status_ff <= cmd.status;
               if (cmd.status != ppa3_pkg::ST_OK) area_ff <= '0;
               else if (|root_ff[RW-1:OW])        area_ff <= '1;
               else                               area_ff <= root_ff[OW-1:0];
               normal_ff    <= '0;
               sums_ff      <= '0;
               nonplanar_ff <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   assign flags.nonplanar = nonplanar_ff;
   assign flags.nc_zero   = (nc == '0);
   assign area            = area_ff;
   assign status          = status_ff;

endmodule

`default_nettype wire

### rtl/ppa3_ctrl.sv
// ---------------------------------------------------------------------------
// ppa3_ctrl
// Sequencer: steps the datapath through the per-vertex products and, on the
// closing vertex, the serial multiply, square root and divide.
// ---------------------------------------------------------------------------
`default_nettype none

module ppa3_ctrl #(
   parameter int COORD_WIDTH = ppa3_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_last_vertex,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire ppa3_pkg::flags_type flags,
   output ppa3_pkg::cmd_type        cmd
);

   localparam int BW  = ppa3_pkg::mplier_w(COORD_WIDTH);
   localparam int RW  = ppa3_pkg::root_w(COORD_WIDTH);
   localparam int ITW = $clog2((BW > RW) ? BW : RW);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_PAIR   = 5'd1;
   localparam logic [4:0] S_NORM   = 5'd2;
   localparam logic [4:0] S_TRIP   = 5'd3;
   localparam logic [4:0] S_DRAIN  = 5'd4;
   localparam logic [4:0] S_CHECK  = 5'd5;
   localparam logic [4:0] S_STAT   = 5'd6;
   localparam logic [4:0] S_CLOSE  = 5'd7;
   localparam logic [4:0] S_CDRAIN = 5'd8;
   localparam logic [4:0] S_FSEL   = 5'd9;
   localparam logic [4:0] S_MLOAD  = 5'd10;
   localparam logic [4:0] S_MSTEP  = 5'd11;
   localparam logic [4:0] S_MSAVE  = 5'd12;
   localparam logic [4:0] S_SLOAD  = 5'd13;
   localparam logic [4:0] S_SSTEP  = 5'd14;
   localparam logic [4:0] S_DLOAD  = 5'd15;
   localparam logic [4:0] S_DSTEP  = 5'd16;
   localparam logic [4:0] S_EMIT   = 5'd17;

   localparam logic [ITW-1:0] LAST_PROD = ITW'(5);

   logic [4:0]     state_ff, state_in;
   logic [ITW-1:0] it_ff, it_in;
   logic [2:0]     vcnt_ff, vcnt_in;
   logic           last_ff, last_in;
   logic [2:0]     msrc_ff, msrc_in;
   logic [1:0]     st_ff, st_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      it_in        = it_ff;
      vcnt_in      = vcnt_ff;
      last_in      = last_ff;
      msrc_in      = msrc_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.op       = ppa3_pkg::OP_NOP;
      it_in        = (it_ff != '0) ? it_ff - ITW'(1) : it_ff;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op  = ppa3_pkg::OP_ACCEPT;
               cmd.sel = (vcnt_ff == 3'd0) ? ppa3_pkg::SLOT_FIRST :
                         (vcnt_ff == 3'd1) ? ppa3_pkg::SLOT_SECOND : ppa3_pkg::SLOT_NONE;
               last_in  = req_last_vertex;
               it_in    = LAST_PROD;
               state_in = (vcnt_ff == 3'd0) ? S_CHECK : S_PAIR;
            end
         end
         S_PAIR, S_NORM, S_TRIP, S_CLOSE: begin
            case (state_ff)
               S_PAIR:  cmd.op = ppa3_pkg::OP_PAIR;
               S_NORM:  cmd.op = ppa3_pkg::OP_NORM;
               S_TRIP:  cmd.op = ppa3_pkg::OP_TRIP;
               default: cmd.op = ppa3_pkg::OP_CLOSE;
            endcase
            cmd.sel  = {1'b0, it_ff[2:1]};
            cmd.half = it_ff[0];
            if (it_ff == '0) begin
               it_in = LAST_PROD;
               if (state_ff == S_CLOSE)      state_in = S_CDRAIN;
               else if (state_ff != S_PAIR)  state_in = S_DRAIN;
               else if (vcnt_ff == 3'd1)     state_in = S_DRAIN;
               else if (vcnt_ff == 3'd2)     state_in = S_NORM;
               else                          state_in = S_TRIP;
            end
         end
         S_DRAIN: state_in = S_CHECK;
         S_CHECK: begin
            cmd.op  = ppa3_pkg::OP_CHECK;
            cmd.aux = (vcnt_ff >= 3'd3);
            vcnt_in = (vcnt_ff == 3'd4) ? 3'd4 : vcnt_ff + 3'd1;
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (vcnt_ff < 3'd2) begin
               st_in    = ppa3_pkg::ST_FEW;
               state_in = S_EMIT;
            end else begin
               state_in = S_STAT;
            end
         end
         S_STAT: begin
            it_in = LAST_PROD;
            if (flags.nonplanar) begin
               st_in    = ppa3_pkg::ST_NONPLANAR;
               state_in = S_EMIT;
            end else begin
               state_in = S_CLOSE;
            end
         end
         S_CDRAIN: state_in = S_FSEL;
         S_FSEL: begin
            if (flags.nc_zero) begin
               st_in    = ppa3_pkg::ST_DEGEN;
               state_in = S_EMIT;
            end else begin
               msrc_in  = ppa3_pkg::MSRC_SMAG;
               state_in = S_MLOAD;
            end
         end
         S_MLOAD: begin
            cmd.op   = ppa3_pkg::OP_MLOAD;
            cmd.sel  = msrc_ff;
            it_in    = ITW'(BW - 1);
            state_in = S_MSTEP;
         end
         S_MSTEP: begin
            cmd.op = ppa3_pkg::OP_MSTEP;
            if (it_ff == '0) state_in = S_MSAVE;
         end
         S_MSAVE: begin
            cmd.op  = ppa3_pkg::OP_MSAVE;
            cmd.sel = msrc_ff;
            if (msrc_ff == ppa3_pkg::MSRC_XQ) begin
               state_in = S_SLOAD;
            end else begin
               msrc_in  = msrc_ff + 3'd1;
               state_in = S_MLOAD;
            end
         end
         S_SLOAD: begin
            cmd.op   = ppa3_pkg::OP_SLOAD;
            it_in    = ITW'(RW - 1);
            state_in = S_SSTEP;
         end
         S_SSTEP: begin
            cmd.op = ppa3_pkg::OP_SSTEP;
            if (it_ff == '0) state_in = S_DLOAD;
         end
         S_DLOAD: begin
            cmd.op   = ppa3_pkg::OP_DLOAD;
            it_in    = ITW'(RW - 1);
            state_in = S_DSTEP;
         end
         S_DSTEP: begin
            cmd.op = ppa3_pkg::OP_DSTEP;
            if (it_ff == '0) begin
               st_in    = ppa3_pkg::ST_OK;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.op       = ppa3_pkg::OP_EMIT;
               cmd.status   = st_ff;
               rsp_valid_in = 1'b1;
               vcnt_in      = 3'd0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         it_ff        <= '0;
         vcnt_ff      <= 3'd0;
         last_ff      <= 1'b0;
         msrc_ff      <= ppa3_pkg::MSRC_SMAG;
         st_ff        <= ppa3_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         it_ff        <= it_in;
         vcnt_ff      <= vcnt_in;
         last_ff      <= last_in;
         msrc_ff      <= msrc_in;
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      vcnt_ff <= 3'd4)
      else $error("vertex count beyond saturation");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != S_IDLE)
      else $error("accepted word not processed");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_EMIT)
      else $error("result raised outside emit");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT && out_free |=> vcnt_ff == 3'd0 && rsp_valid_ff)
      else $error("emit did not publish and clear");

endmodule

`default_nettype wire

### rtl/planar_polygon_area_3d.sv
// ---------------------------------------------------------------------------
// planar_polygon_area_3d
// Area of a planar polygon in 3-D from a stream of fixed-point vertices.
// ---------------------------------------------------------------------------
//  channel  | handshake                    | word
//  req      | req_valid / req_ready        | vertex x, y, z, last flag
//  rsp      | rsp_valid / rsp_ready        | area (64b, 16 frac), status
//  csr      | csr_write_enable             | coplanar tolerance (62b)
//
// The first vertex is only stored; the second takes six products for the
// shoelace pairs, later ones add six for the normal or triple
// product, all through one shared signed multiplier and its accumulators.
// The closing vertex adds the ring closure, five serial squarings/products
// with a BW-bit multiplier (BW = max(64, 4*COORD_WIDTH+6)), then a square
// root and a divide, each giving RW = (128+BW)/2 result bits.
// Reset is synchronous; the tolerance returns to about 0.01. A result waits in
// the output register while the next polygon's vertices are taken; a second
// result holds the sequencer until the first is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module planar_polygon_area_3d #(
   parameter int COORD_WIDTH = ppa3_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [COORD_WIDTH-1:0]     req_vertex_x,
   input  wire logic signed [COORD_WIDTH-1:0]     req_vertex_y,
   input  wire logic signed [COORD_WIDTH-1:0]     req_vertex_z,
   input  wire logic                              req_last_vertex,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [ppa3_pkg::AREA_WIDTH-1:0]        rsp_area,
   output logic [ppa3_pkg::STATUS_WIDTH-1:0]      rsp_status,
   input  wire logic                              csr_write_enable,
   input  wire logic [ppa3_pkg::TOL_WIDTH-1:0]    csr_write_data
);

   ppa3_pkg::cmd_type   cmd;     // sequencer to datapath
   ppa3_pkg::flags_type flags;   // datapath to sequencer

   ppa3_ctrl #(.COORD_WIDTH(COORD_WIDTH)) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_last_vertex (req_last_vertex),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .flags           (flags),
      .cmd             (cmd)
   );

   // vertex store, multiplier, accumulators, root/divide, result register
   ppa3_dp #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .vertex_x         (req_vertex_x),
      .vertex_y         (req_vertex_y),
      .vertex_z         (req_vertex_z),
      .cmd              (cmd),
      .flags            (flags),
      .area             (rsp_area),
      .status           (rsp_status)
   );

endmodule

`default_nettype wire
